// File: rtl/gha_pkg.sv
package gha_pkg;

	localparam int HANDLE_W       = 32;
	localparam int SLOT_W         = 10;
	localparam int GEN_W          = 21;
	localparam int DEF_LOG2_SLOTS = 10;
	localparam int DEF_SLOTS      = 1024;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;
	localparam logic [1:0] ST_FREED  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// one slot record: in-use flag, issued handle, parent
	typedef struct packed {
		logic                in_use;
		logic [HANDLE_W-1:0] handle;
		logic [HANDLE_W-1:0] parent;
	} slot_rec_t;

endpackage

// File: rtl/gha_req_if.sv
interface gha_req_if
	import gha_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [1:0]          opcode;
	logic [HANDLE_W-1:0] handle_in;
	logic [SLOT_W-1:0]   slot_in;
	logic [HANDLE_W-1:0] parent_in;

	modport source (output valid, opcode, handle_in, slot_in, parent_in, input ready);
	modport sink   (input valid, opcode, handle_in, slot_in, parent_in, output ready);
endinterface

// File: rtl/gha_rsp_if.sv
interface gha_rsp_if
	import gha_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] handle_out;
	logic [SLOT_W-1:0]   slot_out;
	logic [HANDLE_W-1:0] parent_out;

	modport source (output valid, status, handle_out, slot_out, parent_out, input ready);
	modport sink   (input valid, status, handle_out, slot_out, parent_out, output ready);
endinterface

// File: rtl/generation_handle_allocator.sv
// Generational handle allocator.
// req channel: one transaction per request (allocate, free slot, look up
// handle); rsp channel: exactly one transaction per request, in order.
// Allocate pops the most recently freed slot, else the lowest slot never
// used, bumps the 21-bit generation and returns a handle of
// (generation << (LOG2_SLOTS+1)) | slot. Free pushes an in-use slot back;
// a second free is reported and leaves the state alone. Lookup checks the
// handle against the stored record and returns its parent.
// Flow: on accept, the slot record memory and the freed-slot stack are
// read; in the execute state the record is modified and written back
// and the output register is loaded. A new request is taken only after
// this single read-then-write memory pass has finished.
// The output register decouples the sides: a finished response may wait
// while the next request is taken; a further request stalls in its
// execute state until the waiting response is taken.
// Reset clears the counters and the response valid at once; no clearing
// pass is run: records at or above the fresh-slot count read as free.
module generation_handle_allocator
	import gha_pkg::*;
#(
	parameter int LOG2_SLOTS = DEF_LOG2_SLOTS,
	parameter int SLOTS      = DEF_SLOTS
) (
	input  logic clk,
	input  logic arst_n,
	gha_req_if.sink   req,
	gha_rsp_if.source rsp
);

	localparam int IW = LOG2_SLOTS;

	state_t state_q;

	// counters: freed-stack depth, next never-used slot, generation
	logic [IW:0]      freed_count_q;
	logic [IW:0]      fresh_next_q;
	logic [GEN_W-1:0] gen_q;

	// memories
	slot_rec_t       rec_mem [SLOTS];
	logic [IW-1:0]   stack_mem [SLOTS];

	// request held for the execute state
	logic [1:0]          op_s1;
	logic [IW-1:0]       slot_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [HANDLE_W-1:0] parent_s1;
	logic                range_s1;
	logic                seen_s1;
	slot_rec_t           rec_s1;
	logic [IW-1:0]       stk_s1;

	// output register
	logic                rsp_valid_q;
	logic [1:0]          status_q;
	logic [HANDLE_W-1:0] handle_out_q;
	logic [SLOT_W-1:0]   slot_out_q;
	logic [HANDLE_W-1:0] parent_out_q;

	logic          acc;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] look_idx;
	logic [IW-1:0] rd_idx;
	logic          free_range;
	logic          look_range;
	logic          rd_range;
	logic [IW:0]   cnt_m1;

	assign req.ready  = (state_q == S_IDLE);
	assign acc        = req.valid && req.ready;
	assign free_idx   = IW'(req.slot_in);
	assign look_idx   = req.handle_in[IW-1:0];
	assign free_range = (HANDLE_W'(req.slot_in) < HANDLE_W'(SLOTS));
	assign look_range = (HANDLE_W'(look_idx) < HANDLE_W'(SLOTS));
	assign rd_idx     = (req.opcode == OP_FREE) ? free_idx : look_idx;
	assign rd_range   = (req.opcode == OP_FREE) ? free_range : look_range;
	assign cnt_m1     = freed_count_q - (IW+1)'(1);

	// execute state: modify
	logic          load;
	logic          have_freed;
	logic          have_fresh;
	logic [IW-1:0] alloc_slot;
	logic [GEN_W-1:0] gen_nx;
	logic [HANDLE_W-1:0] new_handle;

	logic                rec_we;
	logic [IW-1:0]       rec_waddr;
	slot_rec_t           rec_wdata;
	logic                stk_we;
	logic                cnt_dec;
	logic                cnt_inc;
	logic                fresh_inc;
	logic                gen_inc;
	logic [1:0]          status_d;
	logic [HANDLE_W-1:0] handle_out_d;
	logic [SLOT_W-1:0]   slot_out_d;
	logic [HANDLE_W-1:0] parent_out_d;

	assign load       = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
	assign have_freed = (freed_count_q != '0);
	assign have_fresh = (fresh_next_q < (IW+1)'(SLOTS));
	assign alloc_slot = have_freed ? stk_s1 : fresh_next_q[IW-1:0];
	assign gen_nx     = gen_q + GEN_W'(1);
	assign new_handle = HANDLE_W'({gen_nx, 1'b0, alloc_slot});

	always_comb begin
		rec_we       = 1'b0;
		rec_waddr    = slot_s1;
		rec_wdata    = rec_s1;
		stk_we       = 1'b0;
		cnt_dec      = 1'b0;
		cnt_inc      = 1'b0;
		fresh_inc    = 1'b0;
		gen_inc      = 1'b0;
		status_d     = ST_BAD;
		handle_out_d = '0;
		slot_out_d   = '0;
		parent_out_d = '0;
		unique case (op_s1)
			OP_ALLOC: begin
				if (have_freed || have_fresh) begin
					status_d         = ST_OK;
					handle_out_d     = new_handle;
					slot_out_d       = SLOT_W'(alloc_slot);
					rec_we           = 1'b1;
					rec_waddr        = alloc_slot;
					rec_wdata.in_use = 1'b1;
					rec_wdata.handle = new_handle;
					rec_wdata.parent = parent_s1;
					cnt_dec          = have_freed;
					fresh_inc        = !have_freed;
					gen_inc          = 1'b1;
				end else begin
					status_d = ST_NOFREE;
				end
			end
			OP_FREE: begin
				if (!range_s1) begin
					status_d = ST_BAD;
				end else if (!(seen_s1 && rec_s1.in_use)) begin
					status_d   = ST_FREED;
					slot_out_d = SLOT_W'(slot_s1);
				end else begin
					status_d         = ST_OK;
					slot_out_d       = SLOT_W'(slot_s1);
					rec_we           = 1'b1;
					rec_wdata.in_use = 1'b0;
					stk_we           = (freed_count_q < (IW+1)'(SLOTS));
					cnt_inc          = stk_we;
				end
			end
			OP_LOOKUP: begin
				if (seen_s1 && rec_s1.in_use && rec_s1.handle == handle_s1) begin
					status_d     = ST_OK;
					slot_out_d   = SLOT_W'(slot_s1);
					parent_out_d = rec_s1.parent;
				end
			end
			default: status_d = ST_BAD;
		endcase
	end

	// memories: reads on accept, writes on load
	always_ff @(posedge clk) begin
		if (acc) begin
			rec_s1 <= rec_mem[rd_idx];
			stk_s1 <= stack_mem[cnt_m1[IW-1:0]];
		end
		if (load && rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		if (load && stk_we) begin
			stack_mem[freed_count_q[IW-1:0]] <= slot_s1;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= req.opcode;
			slot_s1   <= rd_idx;
			handle_s1 <= req.handle_in;
			parent_s1 <= req.parent_in;
			range_s1  <= rd_range;
			// records at or above the fresh count were never written
			seen_s1   <= rd_range && ((IW+1)'(rd_idx) < fresh_next_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			freed_count_q <= '0;
			fresh_next_q  <= '0;
			gen_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) state_q <= S_EXEC;
				S_EXEC: if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (load) begin
				if (cnt_dec) freed_count_q <= cnt_m1;
				if (cnt_inc) freed_count_q <= freed_count_q + (IW+1)'(1);
				if (fresh_inc) fresh_next_q <= fresh_next_q + (IW+1)'(1);
				if (gen_inc) gen_q <= gen_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q     <= status_d;
			handle_out_q <= handle_out_d;
			slot_out_q   <= slot_out_d;
			parent_out_q <= parent_out_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.handle_out = handle_out_q;
	assign rsp.slot_out   = slot_out_q;
	assign rsp.parent_out = parent_out_q;

	// every freed slot was once handed out fresh
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		freed_count_q <= fresh_next_q)
		else $error("freed count exceeds slots ever used");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_next_q <= (IW+1)'(SLOTS))
		else $error("fresh slot count beyond pool");

	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		load && gen_inc |=> gen_q == GEN_W'($past(gen_q) + GEN_W'(1)))
		else $error("generation not advanced on allocate");

	a_gen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && gen_inc) |=> $stable(gen_q))
		else $error("generation moved without an allocate");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != ST_OK |-> handle_out_q == '0 && parent_out_q == '0)
		else $error("failed response carries payload");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import gha_pkg::*;

	localparam logic [1:0] OP_UNDEF   = 2'd3;  // opcode the block must reject
	localparam int         IDLE_PCT   = 34;    // idle chance per cycle, each side
	localparam int         RAND_ITEMS = 500;
	localparam int         SETTLE_CYC = 6;     // settling margin after the last response
	localparam longint     TIMEOUT_NS = 64'd5_000_000;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [HANDLE_W-1:0] handle_in;
		logic [SLOT_W-1:0]   slot_in;
		logic [HANDLE_W-1:0] parent_in;
	} alloc_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] handle_out;
		logic [SLOT_W-1:0]   slot_out;
		logic [HANDLE_W-1:0] parent_out;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;

	gha_req_if req_ch ();
	gha_rsp_if rsp_ch ();

	generation_handle_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the allocator state, advanced on every accepted request
	logic [SLOT_W-1:0]   freed_slots [DEF_SLOTS];
	int                  freed_depth = 0;
	int                  fresh_slot  = 0;
	int                  live_count  = 0;
	logic                slot_busy   [DEF_SLOTS];
	logic [HANDLE_W-1:0] slot_tag    [DEF_SLOTS];
	logic [HANDLE_W-1:0] slot_owner  [DEF_SLOTS];
	logic [GEN_W-1:0]    gen_count   = '0;

	alloc_rsp_t expected_rsp [$];
	int         fail_count  = 0;
	bit         calm        = 1'b0;  // both sides stop idling while set
	int         hold_cycles = 0;     // receiver hold-off, counted down below

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// Next expected response for one request; updates the shadow state
	function automatic alloc_rsp_t allocator_response(alloc_req_t r);
		alloc_rsp_t        o;
		logic [SLOT_W-1:0] s;
		o        = '0;
		o.status = ST_BAD;
		case (r.opcode)
			OP_ALLOC: begin
				if (freed_depth > 0 || fresh_slot < DEF_SLOTS) begin
					// LIFO reuse first, then the lowest slot never handed out
					if (freed_depth > 0) begin
						freed_depth--;
						s = freed_slots[freed_depth];
					end else begin
						s = SLOT_W'(fresh_slot);
						fresh_slot++;
					end
					gen_count     = gen_count + 1'b1;
					slot_tag[s]   = (HANDLE_W'(gen_count) << (DEF_LOG2_SLOTS + 1))
						| HANDLE_W'(s);
					slot_owner[s] = r.parent_in;
					slot_busy[s]  = 1'b1;
					live_count++;
					o.status     = ST_OK;
					o.handle_out = slot_tag[s];
					o.slot_out   = s;
				end else begin
					o.status = ST_NOFREE;
				end
			end
			OP_FREE: begin
				o.slot_out = r.slot_in;
				if (!slot_busy[r.slot_in]) begin
					o.status = ST_FREED;
				end else begin
					slot_busy[r.slot_in] = 1'b0;
					if (freed_depth < DEF_SLOTS) begin
						freed_slots[freed_depth] = r.slot_in;
						freed_depth++;
					end
					live_count--;
					o.status = ST_OK;
				end
			end
			OP_LOOKUP: begin
				s = r.handle_in[DEF_LOG2_SLOTS-1:0];
				if (slot_busy[s] && slot_tag[s] == r.handle_in) begin
					o.status     = ST_OK;
					o.slot_out   = s;
					o.parent_out = slot_owner[s];
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic alloc_req_t make_req(logic [1:0] op, logic [HANDLE_W-1:0] h,
			logic [SLOT_W-1:0] s, logic [HANDLE_W-1:0] p);
		alloc_req_t r;
		r.opcode    = op;
		r.handle_in = h;
		r.slot_in   = s;
		r.parent_in = p;
		return r;
	endfunction

	// Random slot that has been handed out at least once, busy or free as asked
	function automatic int pick_slot(bit busy);
		int start;
		int k;
		int s;
		start = $urandom_range(DEF_SLOTS - 1);
		for (k = 0; k < DEF_SLOTS; k++) begin
			s = (start + k) % DEF_SLOTS;
			if (s < fresh_slot && slot_busy[s] == busy)
				return s;
		end
		return -1;
	endfunction

	// One request transaction; expectation queued at the accepting edge
	task automatic send_request(alloc_req_t r);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= r.opcode;
		req_ch.handle_in <= r.handle_in;
		req_ch.slot_in   <= r.slot_in;
		req_ch.parent_in <= r.parent_in;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_rsp.push_back(allocator_response(r));
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (expected_rsp.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Receiver: random ready, or a solid hold-off while hold_cycles runs down
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic compare_field(string name, logic [HANDLE_W-1:0] want,
			logic [HANDLE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Response checker, in order against the oldest expectation
	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual status %h",
					$time, rsp_ch.status);
				fail_count++;
			end else begin
				want = expected_rsp.pop_front();
				compare_field("status", HANDLE_W'(want.status), HANDLE_W'(rsp_ch.status));
				compare_field("handle_out", want.handle_out, rsp_ch.handle_out);
				compare_field("slot_out", HANDLE_W'(want.slot_out),
					HANDLE_W'(rsp_ch.slot_out));
				compare_field("parent_out", want.parent_out, rsp_ch.parent_out);
			end
		end
	end

	task automatic test_directed_cases();
		logic [HANDLE_W-1:0] old_tag;
		send_request(make_req(OP_UNDEF, '1, '1, '1));
		// freeing slots that were never allocated: reported, state untouched
		send_request(make_req(OP_FREE, '0, SLOT_W'(0), '0));
		send_request(make_req(OP_FREE, '0, '1, '0));
		send_request(make_req(OP_ALLOC, '1, '1, '0));
		send_request(make_req(OP_ALLOC, '0, '0, '1));
		send_request(make_req(OP_ALLOC, '0, '0, 32'hA5A5_A5A5));
		send_request(make_req(OP_LOOKUP, slot_tag[1], '0, '0));
		// wrong generation, spare bit set, wrong slot bits
		send_request(make_req(OP_LOOKUP, slot_tag[1] ^ (32'h1 << (DEF_LOG2_SLOTS + 1)),
			'0, '0));
		send_request(make_req(OP_LOOKUP, slot_tag[0] | (32'h1 << DEF_LOG2_SLOTS), '0, '0));
		send_request(make_req(OP_LOOKUP, slot_tag[2] ^ 32'h3, '0, '0));
		send_request(make_req(OP_FREE, '0, SLOT_W'(1), '0));
		send_request(make_req(OP_FREE, '0, SLOT_W'(1), '0));
		send_request(make_req(OP_LOOKUP, slot_tag[1], '0, '0));
		old_tag = slot_tag[0];
		send_request(make_req(OP_FREE, '0, SLOT_W'(0), '0));
		// LIFO: slot 0 back first, then slot 1, then a fresh one
		send_request(make_req(OP_ALLOC, '0, '0, 32'h1234_5678));
		send_request(make_req(OP_ALLOC, '0, '0, 32'h8000_0001));
		send_request(make_req(OP_ALLOC, '0, '0, 32'h0000_FFFF));
		send_request(make_req(OP_LOOKUP, slot_tag[0], '0, '0));
		send_request(make_req(OP_LOOKUP, old_tag, '0, '0));
		send_request(make_req(OP_LOOKUP, slot_tag[3], '0, '0));
		send_request(make_req(OP_UNDEF, '0, '0, '0));
		drain_results();
	endtask

	task automatic test_pool_exhaustion();
		int s;
		while (fresh_slot < DEF_SLOTS || freed_depth > 0) begin
			s = pick_slot(1'b1);
			if ($urandom_range(9) == 0 && s >= 0)
				send_request(make_req(OP_LOOKUP, slot_tag[s], $urandom, $urandom));
			else
				send_request(make_req(OP_ALLOC, $urandom, SLOT_W'($urandom), $urandom));
		end
		// pool full: allocate is refused
		repeat (4) send_request(make_req(OP_ALLOC, $urandom, SLOT_W'($urandom), $urandom));
		repeat (3) send_request(make_req(OP_LOOKUP, $urandom, SLOT_W'($urandom), $urandom));
		drain_results();
		repeat (2) send_request(make_req(OP_FREE, $urandom, SLOT_W'($urandom), $urandom));
		repeat (8) send_request(make_req(OP_ALLOC, $urandom, SLOT_W'($urandom), $urandom));
		drain_results();
	endtask

	task automatic test_random_traffic();
		int                  i;
		int                  pick;
		int                  alloc_w;
		int                  s;
		int                  kind;
		logic [HANDLE_W-1:0] h;
		for (i = 0; i < RAND_ITEMS; i++) begin
			// receiver stalls long enough for the block to back up its input
			if (i == 100)
				hold_cycles = 200;
			// sender waits for every outstanding response
			if (i == 400)
				drain_results();
			calm = (i >= 200 && i < 350);
			// steer occupancy towards neither empty nor full
			alloc_w = (live_count < 16) ? 50 : (live_count > 1000) ? 15 : 32;
			pick    = $urandom_range(99);
			if (pick < 5) begin
				send_request(make_req(OP_UNDEF, $urandom, SLOT_W'($urandom), $urandom));
			end else if (pick < 5 + alloc_w) begin
				send_request(make_req(OP_ALLOC, $urandom, SLOT_W'($urandom), $urandom));
			end else if (pick < 35 + alloc_w) begin
				s = pick_slot(1'b1);
				if ($urandom_range(4) == 0 || s < 0)
					s = $urandom_range(DEF_SLOTS - 1);
				send_request(make_req(OP_FREE, $urandom, SLOT_W'(s), $urandom));
			end else begin
				kind = $urandom_range(99);
				s    = pick_slot(1'b1);
				if (kind < 50 && s >= 0) begin
					h = slot_tag[s];
				end else if (kind < 70) begin
					// stale handle of a released slot
					s = pick_slot(1'b0);
					h = (s >= 0) ? slot_tag[s] : $urandom;
				end else if (kind < 85 && s >= 0) begin
					h = slot_tag[s] ^ (32'h1 << $urandom_range(HANDLE_W - 1));
				end else begin
					h = $urandom;
				end
				send_request(make_req(OP_LOOKUP, h, SLOT_W'($urandom), $urandom));
			end
		end
		calm = 1'b0;
		drain_results();
	endtask

	initial begin
		int i;
		for (i = 0; i < DEF_SLOTS; i++)
			slot_busy[i] = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = OP_ALLOC;
		req_ch.handle_in = '0;
		req_ch.slot_in   = '0;
		req_ch.parent_in = '0;
		rsp_ch.ready     = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_pool_exhaustion();
		test_random_traffic();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
